// ===== rtl/swarq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_pkg
// Shared types, codes and constants of the sliding-window ARQ receiver core.
// ----------------------------------------------------------------------------
package swarq_pkg;

   // Sequence numbers are 8 bits wide, so at most this many slots are ever used.
   localparam int unsigned SEQ_SPACE         = 256;
   localparam int unsigned SEQ_W             = 8;
   localparam int unsigned SEQ_SLOTS_DEFAULT = 256;

   // Packet kinds.
   localparam logic [1:0] KIND_DATA    = 2'd0;
   localparam logic [1:0] KIND_LAST    = 2'd1;
   localparam logic [1:0] KIND_OTHER   = 2'd2;
   localparam logic [1:0] KIND_TIMEOUT = 2'd3;

   // Status codes in a result item.
   localparam logic [1:0] STATUS_RECV  = 2'd0;
   localparam logic [1:0] STATUS_CLOSE = 2'd1;
   localparam logic [1:0] STATUS_DONE  = 2'd2;
   localparam logic [1:0] STATUS_ABORT = 2'd3;

   // Transfer phases.
   localparam logic [1:0] PHASE_FIRST = 2'd0;
   localparam logic [1:0] PHASE_RECV  = 2'd1;
   localparam logic [1:0] PHASE_CLOSE = 2'd2;
   localparam logic [1:0] PHASE_END   = 2'd3;

   // Register file.
   localparam int unsigned CSR_ADDR_W   = 3;
   localparam int unsigned CSR_DATA_W   = 32;
   localparam logic        REG_WINDOW   = 1'b0;
   localparam logic [7:0]  WINDOW_RESET = 8'd4;

   // Depth of the queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 2;

   // One classified packet event.
   typedef struct packed {
      logic [1:0]       kind;
      logic [SEQ_W-1:0] seq;
      logic             crc_match;
      logic             seq_zero;
   } pkt_type;

   // One result item.
   typedef struct packed {
      logic [8:0] ack_seq;
      logic       send_ack;
      logic       store_payload;
      logic       duplicate;
      logic [1:0] status;
   } result_type;

endpackage

// ===== rtl/swarq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_front
// Accepts packet events, classifies them and works out their slot index,
// then holds them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module swarq_front
   import swarq_pkg::*;
#(
   parameter int unsigned SEQ_SLOTS = SEQ_SLOTS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [1:0]          in_kind,
   input  logic [SEQ_W-1:0]    in_seq,
   input  logic                in_crc_match,
   output logic                q_valid,
   input  logic                q_pop,
   output pkt_type             q_pkt,
   output logic [((SEQ_SLOTS < SEQ_SPACE) ? $clog2(SEQ_SLOTS) : SEQ_W)-1:0] q_idx
);

   localparam int unsigned SLOT_DEPTH = (SEQ_SLOTS < SEQ_SPACE) ? SEQ_SLOTS : SEQ_SPACE;
   localparam int unsigned IDX_W      = $clog2(SLOT_DEPTH);
   localparam int unsigned PTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1);

   logic [IDX_W-1:0] idx_table [SEQ_SPACE];
   logic [IDX_W-1:0] slot_idx;
   pkt_type          pkt;
   logic             push;

   pkt_type          pkt_ff [QUEUE_DEPTH];
   logic [IDX_W-1:0] idx_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   // Constant table from sequence number to slot index (seq modulo slot count).
   for (genvar i = 0; i < SEQ_SPACE; i++) begin : g_idx
      localparam int unsigned Rem = i % SEQ_SLOTS;
      assign idx_table[i] = IDX_W'(Rem);
   end

   // Classify the incoming item.
   always_comb begin
      pkt.kind      = in_kind;
      pkt.seq       = in_seq;
      pkt.crc_match = in_crc_match;
      pkt.seq_zero  = (in_seq == '0);
      slot_idx      = idx_table[in_seq];
   end

   // The queue takes an item whenever it has room.
   assign in_stall = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign push     = in_valid && !in_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (q_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         pkt_ff[wr_ptr_ff] <= pkt;
         idx_ff[wr_ptr_ff] <= slot_idx;
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_pkt   = pkt_ff[rd_ptr_ff];
   assign q_idx   = idx_ff[rd_ptr_ff];

endmodule

// ===== rtl/swarq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swarq_back
// Carries out queued packet events against the transfer state and the slot
// map memory, and holds each result item in an output register until it is
// taken. The slot map is read into a register when an item is loaded, ahead
// of its decision, and is cleared one entry per cycle after reset.
// ----------------------------------------------------------------------------
module swarq_back
   import swarq_pkg::*;
#(
   parameter int unsigned SEQ_SLOTS = SEQ_SLOTS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [7:0]       window_size,
   input  logic             q_valid,
   output logic             q_pop,
   input  pkt_type          q_pkt,
   input  logic [((SEQ_SLOTS < SEQ_SPACE) ? $clog2(SEQ_SLOTS) : SEQ_W)-1:0] q_idx,
   output logic             out_valid,
   input  logic             out_stall,
   output result_type       out_result
);

   localparam int unsigned SLOT_DEPTH = (SEQ_SLOTS < SEQ_SPACE) ? SEQ_SLOTS : SEQ_SPACE;
   localparam int unsigned IDX_W      = $clog2(SLOT_DEPTH);

   // Slot map memory and its clearing pass.
   logic                  slot_mem [SLOT_DEPTH];
   logic                  clearing_ff;
   logic [IDX_W-1:0]      clear_idx_ff;
   logic                  slot_rd_ff;
   logic                  fwd_ff, fwd_in;
   logic                  mem_we;
   logic [IDX_W-1:0]      mem_waddr;
   logic                  mem_wdata;

   // Item whose slot has been read and which waits for its decision.
   logic                  exe_valid_ff, exe_valid_in;
   pkt_type               exe_pkt_ff;
   logic [IDX_W-1:0]      exe_idx_ff;

   logic [1:0]            phase_ff, phase_in;
   logic [SEQ_W-1:0]      expected_ff, expected_in;
   logic [SEQ_W-1:0]      last_ack_ff, last_ack_in;
   logic                  valid_ff, valid_in;
   result_type            result_ff;

   logic                  go;
   logic                  load;
   logic                  has_result;
   logic                  mark;
   logic                  slot_full;
   logic [8:0]            prev_ack;
   logic signed [9:0]     close_low;
   logic                  close_ok;
   logic                  is_data;
   result_type            res;

   // The waiting item is carried out when the output register is free or being
   // emptied. A new item is taken from the queue when the waiting slot is free
   // or being freed, and never during the clearing pass.
   assign go    = exe_valid_ff && (!valid_ff || !out_stall);
   assign load  = !clearing_ff && (!exe_valid_ff || go);
   assign q_pop = q_valid && load;

   always_comb begin
      exe_valid_in = exe_valid_ff;
      if (q_pop) begin
         exe_valid_in = 1'b1;
      end else if (go) begin
         exe_valid_in = 1'b0;
      end
   end

   // The slot written at the edge where the next item is read is forwarded.
   assign fwd_in = go && mark && (q_idx == exe_idx_ff);

   // Shared compares for the waiting item.
   always_comb begin
      slot_full = slot_rd_ff || fwd_ff;
      prev_ack  = {1'b0, expected_ff} - 9'd1;
      close_low = $signed({2'b00, expected_ff}) - $signed({2'b00, window_size});
      close_ok  = $signed({2'b00, exe_pkt_ff.seq}) > close_low;
      is_data   = (exe_pkt_ff.kind == KIND_DATA) || (exe_pkt_ff.kind == KIND_LAST);
   end

   // Decide the result and the next state.
   always_comb begin
      phase_in    = phase_ff;
      expected_in = expected_ff;
      last_ack_in = last_ack_ff;
      has_result  = 1'b0;
      mark        = 1'b0;
      res         = '0;
      case (phase_ff)
         PHASE_END: begin
            has_result = 1'b0;
         end
         PHASE_CLOSE: begin
            has_result = 1'b1;
            if (exe_pkt_ff.kind == KIND_DATA && close_ok) begin
               res.ack_seq  = {1'b0, last_ack_ff};
               res.send_ack = 1'b1;
               res.status   = STATUS_CLOSE;
            end else begin
               phase_in   = PHASE_END;
               res.status = STATUS_DONE;
            end
         end
         PHASE_FIRST, PHASE_RECV: begin
            if (phase_ff == PHASE_FIRST && exe_pkt_ff.kind == KIND_TIMEOUT) begin
               has_result = 1'b0;
            end else if (phase_ff == PHASE_FIRST && !exe_pkt_ff.seq_zero) begin
               phase_in   = PHASE_END;
               has_result = 1'b1;
               res.status = STATUS_ABORT;
            end else begin
               phase_in = PHASE_RECV;
               if (is_data && exe_pkt_ff.crc_match) begin
                  has_result   = 1'b1;
                  res.send_ack = 1'b1;
                  res.status   = STATUS_RECV;
                  if (exe_pkt_ff.seq == expected_ff) begin
                     mark              = 1'b1;
                     res.ack_seq       = {1'b0, expected_ff};
                     res.store_payload = !slot_full;
                     res.duplicate     = slot_full;
                     if (exe_pkt_ff.kind == KIND_LAST) begin
                        phase_in    = PHASE_CLOSE;
                        last_ack_in = expected_ff;
                        res.status  = STATUS_CLOSE;
                     end else begin
                        expected_in = expected_ff + 1'b1;
                     end
                  end else if (exe_pkt_ff.seq > expected_ff) begin
                     mark              = 1'b1;
                     res.ack_seq       = prev_ack;
                     res.store_payload = !slot_full;
                     res.duplicate     = slot_full;
                  end else begin
                     res.ack_seq = prev_ack;
                  end
               end
            end
         end
         default: begin
            has_result = 1'b0;
         end
      endcase
   end

   // Output register handshake.
   always_comb begin
      valid_in = valid_ff;
      if (go && has_result) begin
         valid_in = 1'b1;
      end else if (valid_ff && !out_stall) begin
         valid_in = 1'b0;
      end
   end

   // Transfer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         expected_ff  <= '0;
         last_ack_ff  <= '0;
         exe_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         exe_valid_ff <= exe_valid_in;
         if (go) begin
            phase_ff    <= phase_in;
            expected_ff <= expected_in;
            last_ack_ff <= last_ack_in;
         end
      end
   end

   // Clearing pass over the slot map after reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clear_idx_ff <= '0;
      end else if (clearing_ff) begin
         if (clear_idx_ff == IDX_W'(SLOT_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
         clear_idx_ff <= clear_idx_ff + 1'b1;
      end
   end

   // One write port: clearing first, then marking the carried-out slot.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = exe_idx_ff;
      mem_wdata = 1'b1;
      if (clearing_ff) begin
         mem_we    = 1'b1;
         mem_waddr = clear_idx_ff;
         mem_wdata = 1'b0;
      end else if (go && mark) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Load the next item together with the registered read of its slot.
   always_ff @(posedge clock) begin
      if (q_pop) begin
         exe_pkt_ff <= q_pkt;
         exe_idx_ff <= q_idx;
         slot_rd_ff <= slot_mem[q_idx];
         fwd_ff     <= fwd_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (go && has_result) begin
         result_ff <= res;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/sliding_window_arq_receiver_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_arq_receiver_core
// Receiver side of a sliding-window ARQ link: acknowledges packet events,
// tracks stored slots and walks the transfer through its phases.
// ----------------------------------------------------------------------------
// The core takes one packet event per clock cycle when not stalled and gives
// at most one result item for it. A front end classifies each item into a
// two-entry queue. The back end reads the item's slot from the slot map into a
// register, then decides the result and writes the slot back, so it finishes
// one item per cycle while results are taken; with an empty queue and a free
// result channel an item passes through the queue, the waiting-item register
// and the output register. The input stalls only when the queue is full, that
// is while a stalled result or the clearing pass holds up the back end. After
// reset the slot map is cleared one entry per cycle (at most 256 entries);
// meanwhile up to two items are accepted and wait. The window size register
// sits at byte address 0 and must be written only while nothing is in flight.
module sliding_window_arq_receiver_core
   import swarq_pkg::*;
#(
   parameter int unsigned SEQ_SLOTS = SEQ_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Input channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [1:0]            req_kind,
   input  logic [SEQ_W-1:0]      req_seq,
   input  logic                  req_crc_match,
   // Result channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic signed [8:0]     rsp_ack_seq,
   output logic                  rsp_send_ack,
   output logic                  rsp_store_payload,
   output logic                  rsp_duplicate,
   output logic [1:0]            rsp_status,
   // Configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int unsigned SLOT_DEPTH = (SEQ_SLOTS < SEQ_SPACE) ? SEQ_SLOTS : SEQ_SPACE;
   localparam int unsigned IDX_W      = $clog2(SLOT_DEPTH);

   logic [7:0]       window_ff;
   logic             csr_write;
   logic             q_valid;
   logic             q_pop;
   pkt_type          q_pkt;
   logic [IDX_W-1:0] q_idx;
   result_type       result;

   // Register file: one window size register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= WINDOW_RESET;
      end else if (csr_write && csr_paddr[2] == REG_WINDOW) begin
         window_ff <= csr_pwdata[7:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_WINDOW) begin
         csr_prdata = {{(CSR_DATA_W - 8){1'b0}}, window_ff};
      end
   end

   // Front end: accept, classify and queue.
   swarq_front #(
      .SEQ_SLOTS (SEQ_SLOTS)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (req_valid),
      .in_stall     (req_stall),
      .in_kind      (req_kind),
      .in_seq       (req_seq),
      .in_crc_match (req_crc_match),
      .q_valid      (q_valid),
      .q_pop        (q_pop),
      .q_pkt        (q_pkt),
      .q_idx        (q_idx)
   );

   // Back end: transfer state, slot map and result register.
   swarq_back #(
      .SEQ_SLOTS (SEQ_SLOTS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .window_size (window_ff),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_pkt       (q_pkt),
      .q_idx       (q_idx),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_result  (result)
   );

   assign rsp_ack_seq       = result.ack_seq;
   assign rsp_send_ack      = result.send_ack;
   assign rsp_store_payload = result.store_payload;
   assign rsp_duplicate     = result.duplicate;
   assign rsp_status        = result.status;

endmodule
